// ----- hdl/ecp_pkg.sv -----
package ecp_pkg;

  localparam int COUNT_BITS = 16;
  localparam int TICK_BITS  = 32;

  typedef enum logic [1:0] {
    KIND_OVF_RAISE   = 2'd0,
    KIND_OVF_SERVICE = 2'd1,
    KIND_CAPTURE     = 2'd2,
    KIND_REPORT      = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t               req_type;
    logic [COUNT_BITS-1:0]   captured_count;
  } req_t;

  typedef struct packed {
    logic [TICK_BITS-1:0] period_ticks;
    logic [TICK_BITS-1:0] smoothed_ticks;
    logic [TICK_BITS-1:0] capture_time;
    logic                 edges_seen;
  } res_t;

endpackage

// ----- hdl/ecp_if.sv -----
interface ecp_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [ecp_pkg::COUNT_BITS-1:0] captured_count;

  modport source (output valid, req_type, captured_count, input ready);
  modport sink (input valid, req_type, captured_count, output ready);
endinterface

interface ecp_res_if;
  logic                          valid;
  logic                          ready;
  logic [ecp_pkg::TICK_BITS-1:0] period_ticks;
  logic [ecp_pkg::TICK_BITS-1:0] smoothed_ticks;
  logic [ecp_pkg::TICK_BITS-1:0] capture_time;
  logic                          edges_seen;

  modport source (output valid, period_ticks, smoothed_ticks, capture_time, edges_seen,
                  input ready);
  modport sink (input valid, period_ticks, smoothed_ticks, capture_time, edges_seen,
                output ready);
endinterface

// ----- hdl/ecp_in_stage.sv -----
module ecp_in_stage (
  input  logic          clk,
  input  logic          rst,
  ecp_req_if.sink       req,
  output ecp_pkg::req_t item,
  output logic          item_valid,
  input  logic          item_take
);
  import ecp_pkg::*;

  assign req.ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.req_type       <= req_kind_t'(req.req_type);
      item.captured_count <= req.captured_count;
    end
  end

endmodule

// ----- hdl/ecp_smooth.sv -----
module ecp_smooth (
  input  logic [ecp_pkg::TICK_BITS-1:0] period,
  input  logic [ecp_pkg::TICK_BITS-1:0] smoothed,
  output logic [ecp_pkg::TICK_BITS-1:0] average
);
  import ecp_pkg::*;

  // floor(2^19 / 3) + 1; exact quotient by three for any 18-bit value.
  localparam logic [17:0] RECIP3 = 18'd174763;
  localparam int          HALF_W = 17;
  localparam logic [15:0] THIRD_OF_HALF = 16'd43690;  // floor(2^17 / 3)

  function automatic logic [16:0] div3(input logic [17:0] x);
    logic [35:0] prod;
    prod = {18'b0, x} * {18'b0, RECIP3};
    return prod[35:19];
  endfunction

  logic [34:0]       acc;
  logic [33:0]       half_acc;
  logic [HALF_W-1:0] hi;
  logic [HALF_W-1:0] lo;
  logic [16:0]       q_hi;
  logic [16:0]       hi_back;
  logic [1:0]        r_hi;
  logic [16:0]       cand0, cand1, cand2;
  logic [16:0]       low_q;
  logic [33:0]       mid;
  logic [33:0]       total;

  // (p + 5*s) / 6 == ((p + 5*s) >> 1) / 3. The 34-bit dividend is split in two
  // 17-bit halves; the remainder of the upper half carries into the lower one.
  assign acc      = {3'b0, period} + {1'b0, smoothed, 2'b0} + {3'b0, smoothed};
  assign half_acc = acc[34:1];
  assign hi       = half_acc[33:17];
  assign lo       = half_acc[16:0];

  assign q_hi    = div3({1'b0, hi});
  assign hi_back = {q_hi[15:0], 1'b0} + q_hi;
  assign r_hi    = 2'(hi - hi_back);

  // Upper remainder r contributes r*2^17 = r*43690*3 + 2r.
  assign cand0 = div3({1'b0, lo});
  assign cand1 = div3({1'b0, lo} + 18'd2);
  assign cand2 = div3({1'b0, lo} + 18'd4);

  always_comb begin
    case (r_hi)
      2'd0: begin
        low_q = cand0;
        mid   = 34'd0;
      end
      2'd1: begin
        low_q = cand1;
        mid   = {18'b0, THIRD_OF_HALF};
      end
      default: begin
        low_q = cand2;
        mid   = {17'b0, THIRD_OF_HALF, 1'b0};
      end
    endcase
  end

  assign total   = {q_hi, 17'b0} + mid + {17'b0, low_q};
  assign average = total[TICK_BITS-1:0];

endmodule

// ----- hdl/ecp_update.sv -----
module ecp_update #(
  parameter int TIMER_BITS = 16,
  parameter int EXT_BITS   = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  ecp_pkg::req_t item,
  input  logic          item_valid,
  input  logic          out_space,
  output logic          item_take,
  output ecp_pkg::res_t result
);
  import ecp_pkg::*;

  localparam int FULL_W = TIMER_BITS + EXT_BITS;

  logic [EXT_BITS-1:0]   rollover_count, rollover_count_next;
  logic                  overflow_pending, overflow_pending_next;
  logic [TICK_BITS-1:0]  last_time, last_time_next;
  logic                  last_valid, last_valid_next;
  logic [TICK_BITS-1:0]  period_reg, period_reg_next;
  logic [TICK_BITS-1:0]  smoothed_reg, smoothed_reg_next;
  logic                  first_period, first_period_next;
  logic                  edge_flag, edge_flag_next;

  logic [TIMER_BITS+COUNT_BITS-1:0] count_ext;
  logic [TIMER_BITS-1:0]            tval;
  logic                             early_wrap;
  logic [EXT_BITS-1:0]              roll_inc;
  logic [EXT_BITS-1:0]              roll_cap;
  logic [FULL_W-1:0]                full_time;
  logic [FULL_W+TICK_BITS-1:0]      full_pad;
  logic [TICK_BITS-1:0]             now;
  logic [TICK_BITS-1:0]             new_period;
  logic [TICK_BITS-1:0]             average;

  assign item_take = item_valid && out_space;

  assign count_ext  = {{TIMER_BITS{1'b0}}, item.captured_count};
  assign tval       = count_ext[TIMER_BITS-1:0];
  assign roll_inc   = rollover_count + {{(EXT_BITS-1){1'b0}}, 1'b1};
  // A capture in the lower half while an overflow is pending belongs after it.
  assign early_wrap = overflow_pending && !tval[TIMER_BITS-1];
  assign roll_cap   = early_wrap ? roll_inc : rollover_count;
  assign full_time  = {roll_cap, tval};
  assign full_pad   = {{TICK_BITS{1'b0}}, full_time};
  assign now        = full_pad[TICK_BITS-1:0];
  assign new_period = now - last_time;

  ecp_smooth u_smooth (
    .period   (new_period),
    .smoothed (smoothed_reg),
    .average  (average)
  );

  always_comb begin
    rollover_count_next   = rollover_count;
    overflow_pending_next = overflow_pending;
    last_time_next        = last_time;
    last_valid_next       = last_valid;
    period_reg_next       = period_reg;
    smoothed_reg_next     = smoothed_reg;
    first_period_next     = first_period;
    edge_flag_next        = edge_flag;
    case (item.req_type)
      KIND_OVF_RAISE: begin
        overflow_pending_next = 1'b1;
      end
      KIND_OVF_SERVICE: begin
        if (overflow_pending) begin
          rollover_count_next   = roll_inc;
          overflow_pending_next = 1'b0;
        end
      end
      KIND_CAPTURE: begin
        edge_flag_next      = 1'b1;
        rollover_count_next = roll_cap;
        if (early_wrap) begin
          overflow_pending_next = 1'b0;
        end
        if (last_valid) begin
          period_reg_next   = new_period;
          first_period_next = 1'b0;
          smoothed_reg_next = first_period ? new_period : average;
        end
        last_time_next  = now;
        last_valid_next = 1'b1;
      end
      default: begin
        if (edge_flag) begin
          edge_flag_next = 1'b0;
        end else begin
          period_reg_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rollover_count   <= '0;
      overflow_pending <= 1'b0;
      last_time        <= '0;
      last_valid       <= 1'b0;
      period_reg       <= '0;
      smoothed_reg     <= '0;
      first_period     <= 1'b1;
      edge_flag        <= 1'b0;
    end else if (item_take) begin
      rollover_count   <= rollover_count_next;
      overflow_pending <= overflow_pending_next;
      last_time        <= last_time_next;
      last_valid       <= last_valid_next;
      period_reg       <= period_reg_next;
      smoothed_reg     <= smoothed_reg_next;
      first_period     <= first_period_next;
      edge_flag        <= edge_flag_next;
    end
  end

  assign result.period_ticks   = period_reg_next;
  assign result.smoothed_ticks = smoothed_reg_next;
  assign result.capture_time   = last_time_next;
  assign result.edges_seen     = edge_flag_next;

endmodule

// ----- hdl/ecp_out_stage.sv -----
module ecp_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  ecp_pkg::res_t result,
  output logic          out_space,
  ecp_res_if.source     res
);
  import ecp_pkg::*;

  res_t held;

  assign out_space = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_space) begin
      res.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign res.period_ticks   = held.period_ticks;
  assign res.smoothed_ticks = held.smoothed_ticks;
  assign res.capture_time   = held.capture_time;
  assign res.edges_seen     = held.edges_seen;

endmodule

// ----- hdl/encoder_period_capture.sv -----
// Encoder period capture.
// The req channel carries one item per event: timer overflow raised, overflow
// serviced, edge capture with the latched 16-bit timer value, or report tick.
// Every accepted item produces exactly one item on the res channel, holding the
// latest period, the smoothed period, the extended time of the last capture and
// the edge-seen flag, all as they stand after that item has been applied.
// An accepted item is held in the input register. The update is combinational:
// the state and the result register are both written when the item is taken.
// Throughput: one item per cycle while the receiver takes results. The state
// update, including the one-sixth smoothing (a 35-bit add followed by a
// constant reciprocal multiply), is combinational, so consecutive captures
// never wait on each other.
// When the receiver holds res.ready low, the result register keeps its item,
// the input register fills, and req.ready drops; nothing is lost or repeated.
// Reset (synchronous, active high) empties both registers, zeroes the rollover
// count, times and periods, clears the pending and edge flags, and marks that
// neither a previous capture nor a first period exists yet.
module encoder_period_capture #(
  parameter int TIMER_BITS = 16,
  parameter int EXT_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst,
  ecp_req_if.sink   req,
  ecp_res_if.source res
);
  import ecp_pkg::*;

  req_t item;
  logic item_valid;
  logic item_take;
  logic out_space;
  res_t result;

  // Input register: holds one item while the update stage is blocked.
  ecp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  // Rollover extension, period and smoothing state; fires whenever the
  // result register has room for what it produces.
  ecp_update #(
    .TIMER_BITS (TIMER_BITS),
    .EXT_BITS   (EXT_BITS)
  ) u_update (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .out_space  (out_space),
    .item_take  (item_take),
    .result     (result)
  );

  // Result register facing the receiver.
  ecp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (item_take),
    .result    (result),
    .out_space (out_space),
    .res       (res)
  );

endmodule

// ----- hdl/ecp_checker.sv -----
module ecp_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_period,
  input logic [31:0] res_smoothed,
  input logic [31:0] res_time,
  input logic        res_edges
);

  // A result waiting on the receiver keeps its contents.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_period) &&
      $stable(res_smoothed) && $stable(res_time) && $stable(res_edges))
    else $error("stalled result changed");

  // After an item is accepted, a result is on offer: either the new one or an
  // older one still waiting on the receiver.
  a_accept_to_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##2 res_valid)
    else $error("accepted item produced no result");

  // With the result register empty the block always takes a new item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> req_ready)
    else $error("input blocked while output empty");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind encoder_period_capture ecp_checker u_ecp_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_period   (res.period_ticks),
  .res_smoothed (res.smoothed_ticks),
  .res_time     (res.capture_time),
  .res_edges    (res.edges_seen)
);

// ----- tb/encoder_period_capture_tb.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the encoder period capture block.
//
// Requests go in on the req channel and every accepted item yields exactly one
// item on the res channel. A scoreboard object keeps its own copy of the
// capture state (rollover count, pending overflow, last stamp, periods, edge
// flag). It predicts the result of each accepted request and compares the
// results in arrival order, field by field.
//
// The stimulus runs in three parts:
//   - a short directed run through the corner cases: the idle report, a
//     service with nothing pending, a double raise, captures on both sides of
//     half range while an overflow is pending, the first capture and the first
//     period, and reports with and without edges;
//   - descending captures within one rollover period, so all periods but one
//     wrap to just under 2^32. These push the one-sixth smoothing past 32 bits;
//   - a random mix of realistic overflow/capture/service sequences and loose
//     items. The sender gaps and the receiver stalls change every hundred
//     items, and the last stretch runs with no idling.
module encoder_period_capture_tb;
  import ecp_pkg::*;

  // Cycles without any accepted item before the run is declared hung. The
  // longest honest pause is a sender gap next to a receiver stall plus the
  // latency of the block, so this leaves a wide margin.
  localparam int STUCK_LIMIT  = 400;
  localparam int RANDOM_ITEMS = 1700;
  localparam int CALM_ITEMS   = 200;
  localparam int RESHUFFLE    = 100;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED  = 40;

  // Holds the predicted capture state and the results still owed by the block.
  class period_scoreboard;
    bit [COUNT_BITS-1:0]   rollovers;
    bit                    ovf_pending;
    bit [TICK_BITS-1:0]    last_stamp;
    bit                    have_stamp;
    bit [TICK_BITS-1:0]    period;
    bit [TICK_BITS-1:0]    smoothed;
    bit                    awaiting_first = 1'b1;
    bit                    edge_flag;
    res_t                  owed_q[$];
    int                    mismatches;
    int                    requests;
    int                    captures;
    int                    bumps;
    int                    compared;

    function int pending();
      return owed_q.size();
    endfunction

    function void bump_rollover();
      rollovers   = rollovers + 1'b1;
      ovf_pending = 1'b0;
      bumps++;
    endfunction

    // Applies one accepted request to the predicted state and queues the
    // result the block owes for it.
    function void note_request(req_kind_t kind, logic [COUNT_BITS-1:0] count);
      res_t               owed;
      bit [TICK_BITS-1:0] now;
      bit [TICK_BITS+2:0] acc;
      requests++;
      case (kind)
        KIND_OVF_RAISE: begin
          ovf_pending = 1'b1;
        end
        KIND_OVF_SERVICE: begin
          if (ovf_pending) bump_rollover();
        end
        KIND_CAPTURE: begin
          captures++;
          edge_flag = 1'b1;
          if (ovf_pending && !count[COUNT_BITS-1]) bump_rollover();
          now = {rollovers, count};
          if (have_stamp) begin
            period = now - last_stamp;
            if (awaiting_first) begin
              smoothed       = period;
              awaiting_first = 1'b0;
            end else begin
              acc      = {3'b000, period} + {3'b000, smoothed} * 35'd5;
              smoothed = TICK_BITS'(acc / 35'd6);
            end
          end
          last_stamp = now;
          have_stamp = 1'b1;
        end
        KIND_REPORT: begin
          if (edge_flag) edge_flag = 1'b0;
          else period = '0;
        end
        default: begin
        end
      endcase
      owed.period_ticks   = period;
      owed.smoothed_ticks = smoothed;
      owed.capture_time   = last_stamp;
      owed.edges_seen     = edge_flag;
      owed_q.push_back(owed);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compares one accepted result with the oldest outstanding prediction.
    task check_result(res_t got);
      res_t want;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed (period %0h time %0h)",
                                  got.period_ticks, got.capture_time));
        return;
      end
      want = owed_q.pop_front();
      compared++;
      if (got.period_ticks !== want.period_ticks)
        report_mismatch($sformatf("result %0d period_ticks %0h, want %0h",
                                  compared, got.period_ticks, want.period_ticks));
      if (got.smoothed_ticks !== want.smoothed_ticks)
        report_mismatch($sformatf("result %0d smoothed_ticks %0h, want %0h",
                                  compared, got.smoothed_ticks, want.smoothed_ticks));
      if (got.capture_time !== want.capture_time)
        report_mismatch($sformatf("result %0d capture_time %0h, want %0h",
                                  compared, got.capture_time, want.capture_time));
      if (got.edges_seen !== want.edges_seen)
        report_mismatch($sformatf("result %0d edges_seen %0b, want %0b",
                                  compared, got.edges_seen, want.edges_seen));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  ecp_req_if req_if ();
  ecp_res_if res_if ();

  encoder_period_capture DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .res(res_if)
  );

  period_scoreboard board;

  // Idling controls. An odds value of N means a burst starts with chance 1/N
  // per opportunity, and 0 means no idling at all. When calm is set, both sides
  // run flat out.
  int stall_odds;
  int gap_odds;
  bit calm;
  int stuck_cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver sets ready at the falling edge. A stall holds it low for a
  // burst whose length is drawn at random.
  initial begin
    int stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        res_if.ready = 1'b0;
        stall_left   = $urandom_range(0, 9);
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  // Results are taken at the rising edge. An item accepted at this edge
  // cannot also show its result here, because the block registers it first. So
  // the order in which this block and the driver run at one edge does not
  // matter.
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      board.check_result(res_t'({res_if.period_ticks, res_if.smoothed_ticks,
                                 res_if.capture_time, res_if.edges_seen}));
  end

  // Watchdog: any accepted item on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
      $display("[%0t] no item moved for %0d cycles", $time, STUCK_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Presents one request from the falling edge on and holds it until it is
  // accepted. A random sender gap may come first. The task returns at a
  // falling edge with valid still high, so back-to-back items never drop it.
  task send_item(req_kind_t kind, logic [COUNT_BITS-1:0] count);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    req_if.valid          = 1'b1;
    req_if.req_type       = kind;
    req_if.captured_count = count;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    board.note_request(kind, count);
    @(negedge clk);
  endtask

  // Capture values lean toward the range ends and the half-range boundary,
  // where the pending overflow decision flips.
  function logic [COUNT_BITS-1:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return '1;
      default: return COUNT_BITS'($urandom);
    endcase
  endfunction

  // One random step. Three in ten steps copy what firmware sees on a real timer:
  // an overflow is raised, an edge may land before the interrupt is serviced,
  // and then the service usually comes. The rest are loose items in any order,
  // including stray services and back-to-back reports.
  task send_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_item(KIND_OVF_RAISE, COUNT_BITS'($urandom));
      if ($urandom_range(0, 3) != 0) send_item(KIND_CAPTURE, pick_count());
      if ($urandom_range(0, 3) != 0) send_item(KIND_OVF_SERVICE, COUNT_BITS'($urandom));
    end else if (pick < 60) begin
      send_item(KIND_CAPTURE, pick_count());
    end else if (pick < 70) begin
      send_item(KIND_OVF_RAISE, COUNT_BITS'($urandom));
    end else if (pick < 80) begin
      send_item(KIND_OVF_SERVICE, COUNT_BITS'($urandom));
    end else begin
      send_item(KIND_REPORT, COUNT_BITS'($urandom));
    end
  endtask

  function int pick_odds();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 8;
    endcase
  endfunction

  initial begin
    int target;
    int next_shuffle;
    board                 = new();
    stuck_cycles          = 0;
    calm                  = 1'b0;
    stall_odds            = 4;
    gap_odds              = 4;
    req_if.valid          = 1'b0;
    req_if.req_type       = KIND_OVF_RAISE;
    req_if.captured_count = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A report before any edge finds no edges and leaves the period at zero.
    // A service with nothing pending changes nothing.
    send_item(KIND_REPORT, 16'hFFFF);
    send_item(KIND_OVF_SERVICE, 16'h0000);
    // The first capture only stores its time. The report after it just
    // clears the edge flag.
    send_item(KIND_CAPTURE, 16'h0000);
    send_item(KIND_REPORT, 16'h0000);
    // A second raise while one is pending must still count only once.
    send_item(KIND_OVF_RAISE, 16'hAAAA);
    send_item(KIND_OVF_RAISE, 16'h5555);
    // An upper-half capture leaves the overflow pending, and this is the
    // first period, so smoothing takes it as it is. The lower-half capture
    // after it then counts the rollover.
    send_item(KIND_CAPTURE, 16'hFFFF);
    send_item(KIND_CAPTURE, 16'h0000);
    send_item(KIND_CAPTURE, 16'h8000);
    // The first report eats the edge flag. The second finds no edge and
    // clears the period.
    send_item(KIND_REPORT, 16'h1234);
    send_item(KIND_REPORT, 16'h4321);
    send_item(KIND_OVF_RAISE, 16'h0000);
    send_item(KIND_OVF_SERVICE, 16'hFFFF);
    send_item(KIND_OVF_SERVICE, 16'h0000);
    send_item(KIND_CAPTURE, 16'h7FFF);
    send_item(KIND_CAPTURE, 16'h9000);

    // With no rollover in between, the next capture lands below the previous
    // one and its period wraps around.
    gap_odds   = 8;
    stall_odds = 8;
    send_item(KIND_CAPTURE, 16'h1000);
    // The descending captures after the first give periods just under 2^32.
    // The smoothed value climbs, and period plus five times it overflows 32 bits.
    for (int step = 15; step >= 8; step--)
      send_item(KIND_CAPTURE, COUNT_BITS'(step) << 12);
    send_item(KIND_REPORT, 16'h0000);
    send_item(KIND_REPORT, 16'h0000);

    // Random part. Idling changes every hundred items, and the last stretch
    // runs with none.
    target       = board.requests + RANDOM_ITEMS;
    next_shuffle = board.requests;
    while (board.requests < target) begin
      if (board.requests + CALM_ITEMS >= target) begin
        calm = 1'b1;
      end else if (board.requests >= next_shuffle) begin
        stall_odds   = pick_odds();
        gap_odds     = pick_odds();
        next_shuffle = board.requests + RESHUFFLE;
      end
      send_random();
    end
    req_if.valid = 1'b0;

    // Wait until every owed result has been taken, then watch a few more
    // cycles for anything extra. The watchdog bounds this wait.
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests with %0d captures and %0d rollovers.",
             board.requests, board.captures, board.bumps);
    $display("%0d results compared, %0d mismatches.", board.compared, board.mismatches);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ecp_pkg.sv
hdl/ecp_if.sv
hdl/ecp_in_stage.sv
hdl/ecp_smooth.sv
hdl/ecp_update.sv
hdl/ecp_out_stage.sv
hdl/encoder_period_capture.sv
hdl/ecp_checker.sv
tb/encoder_period_capture_tb.sv
